// ===== hw/rtl/lnw_pkg.sv =====
`timescale 1ns / 1ps

package lnw_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int CHAR_W          = 8;
  localparam int NIBBLE_W        = 4;
  localparam int COUNT_W         = 32;
  localparam int TPM_W           = 8;
  localparam int MS_PER_TENTH    = 100;
  localparam int TENTHS_PER_SEC  = 10;
  localparam int MS_DIV_W        = 7;
  localparam int TENTH_DIV_W     = 4;

  localparam logic [TPM_W-1:0] TICKS_PER_MS_RST = 8'd10;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_POLL   = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_TENTH  = 2'd1,
    EV_SECOND = 2'd2
  } event_code_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HIGH   = 3'd1,
    PH_HIGH_W = 3'd2,
    PH_LOW    = 3'd3,
    PH_LOW_W  = 3'd4,
    PH_DONE   = 3'd5
  } seq_phase_t;

  typedef struct packed {
    logic tick;
    logic insert;
    logic poll;
  } item_cmd_t;

  typedef struct packed {
    logic                rs;
    logic                en;
    logic [NIBBLE_W-1:0] nibble;
  } lcd_pins_t;

endpackage

// ===== hw/rtl/lnw_ram.sv =====
`timescale 1ns / 1ps

module lnw_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lnw_timebase.sv =====
`timescale 1ns / 1ps

module lnw_timebase (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lnw_pkg::TPM_W-1:0]         ticks_per_ms,
  input  lnw_pkg::item_cmd_t                cmd,
  output logic                              seq_step,
  output logic [lnw_pkg::COUNT_W-1:0]       ms_total_next,
  output logic [lnw_pkg::COUNT_W-1:0]       sec_total_next,
  output lnw_pkg::event_code_t              event_code
);

  localparam logic [lnw_pkg::MS_DIV_W-1:0] MS_DIV_LAST =
    lnw_pkg::MS_DIV_W'(lnw_pkg::MS_PER_TENTH - 1);
  localparam logic [lnw_pkg::TENTH_DIV_W-1:0] TENTH_DIV_LAST =
    lnw_pkg::TENTH_DIV_W'(lnw_pkg::TENTHS_PER_SEC - 1);

  logic [lnw_pkg::TPM_W-1:0]       tick_divider, tick_divider_next, tick_inc;
  logic [lnw_pkg::MS_DIV_W-1:0]    ms_divider, ms_divider_next;
  logic [lnw_pkg::TENTH_DIV_W-1:0] tenth_divider, tenth_divider_next;
  logic [lnw_pkg::COUNT_W-1:0]     ms_total, sec_total;
  logic                            tenth_flag, tenth_flag_next;
  logic                            second_flag, second_flag_next;
  logic                            ms_hit;

  assign tick_inc = tick_divider + 1'b1;
  assign ms_hit   = cmd.tick && (tick_inc >= ticks_per_ms);
  assign seq_step = cmd.tick && !ms_hit;

  always_comb begin
    tick_divider_next  = tick_divider;
    ms_divider_next    = ms_divider;
    tenth_divider_next = tenth_divider;
    ms_total_next      = ms_total;
    sec_total_next     = sec_total;
    tenth_flag_next    = tenth_flag;
    second_flag_next   = second_flag;
    event_code         = lnw_pkg::EV_NONE;
    if (cmd.tick) begin
      tick_divider_next = ms_hit ? '0 : tick_inc;
    end
    if (ms_hit) begin
      ms_total_next = ms_total + 1'b1;
      if (ms_divider == MS_DIV_LAST) begin
        ms_divider_next = '0;
        tenth_flag_next = 1'b1;
        if (tenth_divider == TENTH_DIV_LAST) begin
          tenth_divider_next = '0;
          sec_total_next     = sec_total + 1'b1;
          second_flag_next   = 1'b1;
        end else begin
          tenth_divider_next = tenth_divider + 1'b1;
        end
      end else begin
        ms_divider_next = ms_divider + 1'b1;
      end
    end
    // the 100 ms flag is reported ahead of the second flag
    if (cmd.poll) begin
      if (tenth_flag) begin
        tenth_flag_next = 1'b0;
        event_code      = lnw_pkg::EV_TENTH;
      end else if (second_flag) begin
        second_flag_next = 1'b0;
        event_code       = lnw_pkg::EV_SECOND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider  <= '0;
      ms_divider    <= '0;
      tenth_divider <= '0;
      ms_total      <= '0;
      sec_total     <= '0;
      tenth_flag    <= 1'b0;
      second_flag   <= 1'b0;
    end else begin
      tick_divider  <= tick_divider_next;
      ms_divider    <= ms_divider_next;
      tenth_divider <= tenth_divider_next;
      ms_total      <= ms_total_next;
      sec_total     <= sec_total_next;
      tenth_flag    <= tenth_flag_next;
      second_flag   <= second_flag_next;
    end
  end

endmodule

// ===== hw/rtl/lnw_lcd_seq.sv =====
`timescale 1ns / 1ps

module lnw_lcd_seq #(
  parameter int DEPTH = lnw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       insert,
  input  logic                       rs_flag,
  input  logic [lnw_pkg::CHAR_W-1:0] char_byte,
  output lnw_pkg::lcd_pins_t         pins_next
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int ENTRY_W = lnw_pkg::CHAR_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0]   write_index, write_index_next, write_inc;
  logic [IDX_W-1:0]   read_index, read_index_next, read_inc;
  lnw_pkg::seq_phase_t phase, phase_next;
  lnw_pkg::lcd_pins_t pins;
  logic [ENTRY_W-1:0] rd_data, head, wr_data;
  logic [ENTRY_W-1:0] byp_data;
  logic               byp_valid;
  logic               head_sel;
  logic [lnw_pkg::CHAR_W-1:0] head_char;

  assign write_inc = (write_index == IDX_LAST) ? '0 : write_index + 1'b1;
  assign read_inc  = (read_index == IDX_LAST) ? '0 : read_index + 1'b1;
  assign wr_data   = {rs_flag, char_byte};

  // head entry: registered ram read, or the entry written in the last cycle
  assign head      = byp_valid ? byp_data : rd_data;
  assign head_sel  = head[ENTRY_W-1];
  assign head_char = head[lnw_pkg::CHAR_W-1:0];

  always_comb begin
    phase_next = phase;
    if (step) begin
      case (phase)
        lnw_pkg::PH_HIGH:   phase_next = lnw_pkg::PH_HIGH_W;
        lnw_pkg::PH_HIGH_W: phase_next = lnw_pkg::PH_LOW;
        lnw_pkg::PH_LOW:    phase_next = lnw_pkg::PH_LOW_W;
        lnw_pkg::PH_LOW_W:  phase_next = lnw_pkg::PH_DONE;
        lnw_pkg::PH_DONE:   phase_next = lnw_pkg::PH_IDLE;
        default: begin
          phase_next = (read_index != write_index) ? lnw_pkg::PH_HIGH : lnw_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    pins_next        = pins;
    read_index_next  = read_index;
    write_index_next = write_index;
    if (step) begin
      case (phase)
        lnw_pkg::PH_HIGH: begin
          pins_next.en     = 1'b0;
          pins_next.nibble = head_char[lnw_pkg::CHAR_W-1 -: lnw_pkg::NIBBLE_W];
        end
        lnw_pkg::PH_HIGH_W: pins_next.en = 1'b1;
        lnw_pkg::PH_LOW: begin
          pins_next.en     = 1'b0;
          pins_next.nibble = head_char[lnw_pkg::NIBBLE_W-1:0];
        end
        lnw_pkg::PH_LOW_W: pins_next.en = 1'b1;
        lnw_pkg::PH_DONE: begin
          pins_next.en    = 1'b0;
          pins_next.rs    = 1'b0;
          read_index_next = read_inc;
        end
        default: begin
          if (read_index != write_index) begin
            pins_next.rs = head_sel;
            pins_next.en = 1'b0;
          end
        end
      endcase
    end
    // full ring drops the oldest entry, even one that is being sent
    if (insert) begin
      write_index_next = write_inc;
      if (write_inc == read_index) begin
        read_index_next = read_inc;
      end
    end
  end

  lnw_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (insert),
    .waddr(write_index),
    .wdata(wr_data),
    .raddr(read_index_next),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    byp_data <= wr_data;
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      phase       <= lnw_pkg::PH_IDLE;
      pins        <= '0;
      byp_valid   <= 1'b0;
    end else begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      phase       <= phase_next;
      pins        <= pins_next;
      byp_valid   <= insert && (write_index == read_index_next);
    end
  end

endmodule

// ===== hw/rtl/lcd_nibble_writer_with_timebase.sv =====
`timescale 1ns / 1ps

// 4-bit character display write queue with a millisecond/second timebase.
// input channel (in_valid/in_ready): req_type selects a tick, an insert of
//   char_byte with rs_flag into the ring, or a poll of the elapsed flags.
// output channel (out_valid/out_ready): one transaction per input
//   transaction with the pin levels, the ms and seconds counts and, on a
//   poll, the elapsed event that was cleared.
// the result is registered and shows in the cycle after acceptance.
// throughput: one transaction per cycle; in_ready stays high while the
//   output register is empty or being taken.
// a stalled receiver holds the result in place and drops in_ready until
//   the result is taken; no item is lost or repeated.
// the ring is a single ram with registered read, always pointed at the
//   next head entry, with a bypass for an entry written the cycle before.
// cfg_we/cfg_wdata load ticks_per_ms (10 after reset); write it while idle.
// reset clears the timebase, the ring pointers, the sequencer and the
//   pins; no clearing pass runs, so items are taken right after reset.
module lcd_nibble_writer_with_timebase #(
  parameter int QUEUE_DEPTH = lnw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lnw_pkg::TPM_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic                         rs_flag,
  input  logic [lnw_pkg::CHAR_W-1:0]   char_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         lcd_rs,
  output logic                         lcd_en,
  output logic [lnw_pkg::NIBBLE_W-1:0] lcd_nibble,
  output logic [lnw_pkg::COUNT_W-1:0]  ms_count,
  output logic [lnw_pkg::COUNT_W-1:0]  seconds_count,
  output logic [1:0]                   elapsed_event
);

  logic [lnw_pkg::TPM_W-1:0]   ticks_per_ms;
  logic                        accept;
  lnw_pkg::item_cmd_t          cmd;
  logic                        seq_step;
  logic [lnw_pkg::COUNT_W-1:0] ms_total_next, sec_total_next;
  lnw_pkg::event_code_t        event_code;
  lnw_pkg::lcd_pins_t          pins_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign cmd.tick   = accept && (req_type == lnw_pkg::REQ_TICK);
  assign cmd.insert = accept && (req_type == lnw_pkg::REQ_INSERT);
  assign cmd.poll   = accept && (req_type == lnw_pkg::REQ_POLL);

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= lnw_pkg::TICKS_PER_MS_RST;
    end else if (cfg_we) begin
      ticks_per_ms <= cfg_wdata;
    end
  end

  lnw_timebase u_timebase (
    .clk           (clk),
    .rst           (rst),
    .ticks_per_ms  (ticks_per_ms),
    .cmd           (cmd),
    .seq_step      (seq_step),
    .ms_total_next (ms_total_next),
    .sec_total_next(sec_total_next),
    .event_code    (event_code)
  );

  lnw_lcd_seq #(
    .DEPTH(QUEUE_DEPTH)
  ) u_lcd_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (seq_step),
    .insert   (cmd.insert),
    .rs_flag  (rs_flag),
    .char_byte(char_byte),
    .pins_next(pins_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      lcd_rs        <= 1'b0;
      lcd_en        <= 1'b0;
      lcd_nibble    <= '0;
      ms_count      <= '0;
      seconds_count <= '0;
      elapsed_event <= lnw_pkg::EV_NONE;
    end else begin
      if (accept) begin
        out_valid     <= 1'b1;
        lcd_rs        <= pins_next.rs;
        lcd_en        <= pins_next.en;
        lcd_nibble    <= pins_next.nibble;
        ms_count      <= ms_total_next;
        seconds_count <= sec_total_next;
        elapsed_event <= event_code;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_event_only_on_poll: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type != lnw_pkg::REQ_POLL) |=> elapsed_event == lnw_pkg::EV_NONE)
    else $error("elapsed event reported for a non-poll transaction");

  a_insert_keeps_pins: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == lnw_pkg::REQ_INSERT) |=>
      lcd_rs == $past(lcd_rs) && lcd_en == $past(lcd_en) &&
      lcd_nibble == $past(lcd_nibble))
    else $error("insert changed the display pin levels");

  a_insert_keeps_counts: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == lnw_pkg::REQ_INSERT) |=>
      ms_count == $past(ms_count) && seconds_count == $past(seconds_count))
    else $error("insert changed the elapsed counts");
`endif

endmodule
